// ===== design/thwg_pkg.sv =====
// Shared types and constants for the task heartbeat watchdog gate.
package thwg_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CIDX_W  = 8;
  localparam int unsigned MASK_W  = 4;
  localparam int unsigned TASK_W  = 2;

  typedef enum logic [1:0] {
    OP_HEARTBEAT = 2'd0,
    OP_CHECK     = 2'd1,
    OP_RESTART   = 2'd2
  } op_e;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] REG_GRACE   = 8'd0;
  localparam logic [CIDX_W-1:0] REG_CH0_TMO = 8'd1;
  localparam logic [CIDX_W-1:0] REG_CH1_TMO = 8'd2;
  localparam logic [CIDX_W-1:0] REG_CH3_TMO = 8'd3;

  localparam logic [CFG_W-1:0] GRACE_RST   = 16'd3000;
  localparam logic [CFG_W-1:0] CH0_TMO_RST = 16'd250;
  localparam logic [CFG_W-1:0] CH1_TMO_RST = 16'd250;
  localparam logic [CFG_W-1:0] CH3_TMO_RST = 16'd1000;

  // Broadcast to every cell on each transfer
  typedef struct packed {
    logic              heartbeat;
    logic              restart;
    logic [TASK_W-1:0] task_index;
    logic [TIME_W-1:0] now;
  } cell_ctrl_t;

endpackage

// ===== design/thwg_if.sv =====
// Channel interfaces: input events, check results and configuration writes.
interface thwg_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 operation;
  logic [thwg_pkg::TASK_W-1:0] task_index;
  logic [thwg_pkg::TIME_W-1:0] now_ms;
  modport source (output valid, output operation, output task_index, output now_ms,
                  input ready);
  modport sink   (input valid, input operation, input task_index, input now_ms,
                  output ready);
endinterface

interface thwg_out_if;
  logic                        valid;
  logic                        ready;
  logic                        refresh_granted;
  logic [thwg_pkg::MASK_W-1:0] stale_mask;
  logic                        recovered;
  logic                        fault_changed;
  modport source (output valid, output refresh_granted, output stale_mask,
                  output recovered, output fault_changed, input ready);
  modport sink   (input valid, input refresh_granted, input stale_mask,
                  input recovered, input fault_changed, output ready);
endinterface

interface thwg_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [thwg_pkg::CIDX_W-1:0] index;
  logic [thwg_pkg::CFG_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/thwg_cell.sv =====
// One task cell: holds the task's heartbeat time and adds its stale flag to the chain.
module thwg_cell #(
  parameter int unsigned IDX     = 0,
  parameter bit          CHECKED = 1'b0
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  thwg_pkg::cell_ctrl_t        ctrl_i,
  input  logic [thwg_pkg::CFG_W-1:0]  timeout_i,
  input  logic [thwg_pkg::MASK_W-1:0] mask_i,
  output logic [thwg_pkg::MASK_W-1:0] mask_o
);

  logic [thwg_pkg::TIME_W-1:0] hb_q, hb_d;
  logic [thwg_pkg::TIME_W-1:0] age;
  logic                        hit;
  logic                        stale;

  assign hit = ctrl_i.heartbeat && (IDX < (1 << thwg_pkg::TASK_W)) &&
               (ctrl_i.task_index == thwg_pkg::TASK_W'(IDX));

  always_comb begin
    hb_d = hb_q;
    if (ctrl_i.restart || hit) begin
      hb_d = ctrl_i.now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hb_q <= '0;
    end else begin
      hb_q <= hb_d;
    end
  end

  // wrapping age against the stored time
  assign age   = ctrl_i.now - hb_q;
  assign stale = age > thwg_pkg::TIME_W'(timeout_i);

  assign mask_o = mask_i |
                  (thwg_pkg::MASK_W'(CHECKED && stale) << IDX);

endmodule

// ===== design/task_heartbeat_watchdog_gate.sv =====
// Top level of the task heartbeat watchdog gate: config, cell chain and result register.
//
// Usage:
//   in_ch_i  carries events: operation (heartbeat, check, restart), task_index, now_ms.
//   out_ch_o carries one result per check: refresh_granted, stale_mask,
//            recovered, fault_changed. Heartbeat, restart and unused codes give none.
//   cfg_i    writes grace window and per-task timeouts; always ready, index past
//            the list is dropped. Write only while the block is idle.
// Latency: a check's result is valid the cycle after its transfer.
// Throughput: one event per cycle. Each task's timestamp lives in its own cell;
//   the cells hand a stale mask down the row in the same cycle, so the next
//   event sees every update. The rate is set by the single output register:
//   an event is taken when that register is empty or is drained in the same cycle.
// Stall: while the receiver holds off, the result stays in the output register
//   and input ready drops until it is taken.
// Reset: timestamps, supervision start and fault mask clear to zero, registers
//   return to defaults (grace 3000, timeouts 250, 250, 1000), no result pending.
module task_heartbeat_watchdog_gate #(
  parameter int unsigned NUM_TASKS = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  thwg_in_if.sink    in_ch_i,
  thwg_out_if.source out_ch_o,
  thwg_cfg_if.sink   cfg_i
);

  localparam int unsigned MW = thwg_pkg::MASK_W;
  localparam int unsigned TW = thwg_pkg::TIME_W;
  localparam int unsigned CW = thwg_pkg::CFG_W;

  // configuration registers
  logic [CW-1:0] grace_q, ch0_tmo_q, ch1_tmo_q, ch3_tmo_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grace_q   <= thwg_pkg::GRACE_RST;
      ch0_tmo_q <= thwg_pkg::CH0_TMO_RST;
      ch1_tmo_q <= thwg_pkg::CH1_TMO_RST;
      ch3_tmo_q <= thwg_pkg::CH3_TMO_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        thwg_pkg::REG_GRACE:   grace_q   <= cfg_i.data;
        thwg_pkg::REG_CH0_TMO: ch0_tmo_q <= cfg_i.data;
        thwg_pkg::REG_CH1_TMO: ch1_tmo_q <= cfg_i.data;
        thwg_pkg::REG_CH3_TMO: ch3_tmo_q <= cfg_i.data;
        default: ;  // unknown index: dropped
      endcase
    end
  end

  // input transfer and decode
  logic               out_valid_q, out_valid_d;
  logic               in_fire;
  logic               is_check;
  logic               is_restart;
  thwg_pkg::cell_ctrl_t ctrl;

  assign in_ch_i.ready = !out_valid_q || out_ch_o.ready;
  assign in_fire       = in_ch_i.valid && in_ch_i.ready;
  assign is_check      = in_fire && (in_ch_i.operation == thwg_pkg::OP_CHECK);
  assign is_restart    = in_fire && (in_ch_i.operation == thwg_pkg::OP_RESTART);

  assign ctrl.heartbeat  = in_fire && (in_ch_i.operation == thwg_pkg::OP_HEARTBEAT);
  assign ctrl.restart    = is_restart;
  assign ctrl.task_index = in_ch_i.task_index;
  assign ctrl.now        = in_ch_i.now_ms;

  // row of task cells; mask accumulates from cell 0 onward
  logic [MW-1:0] chain [NUM_TASKS+1];
  assign chain[0] = '0;

  for (genvar k = 0; k < NUM_TASKS; k++) begin : g_cell
    // only tasks 0, 1 and 3 are supervised
    localparam bit CHK = (k == 0) || (k == 1) || (k == 3);
    logic [CW-1:0] tmo;
    assign tmo = (k == 0) ? ch0_tmo_q :
                 (k == 1) ? ch1_tmo_q :
                 (k == 3) ? ch3_tmo_q : '0;

    thwg_cell #(
      .IDX     (k),
      .CHECKED (CHK)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .timeout_i (tmo),
      .mask_i    (chain[k]),
      .mask_o    (chain[k+1])
    );
  end

  // supervision state
  logic [TW-1:0] start_q, start_d;
  logic [MW-1:0] last_mask_q, last_mask_d;
  logic          in_grace;
  logic [TW-1:0] since_start;

  assign since_start = in_ch_i.now_ms - start_q;
  assign in_grace    = since_start < TW'(grace_q);

  // check evaluation
  logic [MW-1:0] mask;
  logic          granted;
  logic          recovered;
  logic          changed;

  always_comb begin
    mask        = in_grace ? '0 : chain[NUM_TASKS];
    granted     = (mask == '0);
    recovered   = 1'b0;
    changed     = 1'b0;
    start_d     = start_q;
    last_mask_d = last_mask_q;
    if (is_restart) begin
      start_d     = in_ch_i.now_ms;
      last_mask_d = '0;
    end else if (is_check) begin
      if (granted) begin
        recovered   = (last_mask_q != '0);
        last_mask_d = '0;
      end else if (mask != last_mask_q) begin
        changed     = 1'b1;
        last_mask_d = mask;
      end
    end
  end

  // result register
  logic          granted_q;
  logic [MW-1:0] mask_q;
  logic          recovered_q;
  logic          changed_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ch_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (is_check) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      start_q     <= '0;
      last_mask_q <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      start_q     <= start_d;
      last_mask_q <= last_mask_d;
    end
  end

  // payload: loaded only on a check transfer
  always_ff @(posedge clk_i) begin
    if (is_check) begin
      granted_q   <= granted;
      mask_q      <= mask;
      recovered_q <= recovered;
      changed_q   <= changed;
    end
  end

  assign out_ch_o.valid           = out_valid_q;
  assign out_ch_o.refresh_granted = granted_q;
  assign out_ch_o.stale_mask      = mask_q;
  assign out_ch_o.recovered       = recovered_q;
  assign out_ch_o.fault_changed   = changed_q;

endmodule
